/* sv/epa_pkg.sv */
// Shared types and constants for the exhale plateau averager.
package epa_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 16;
  localparam int MEAN_W   = 15;
  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 16;

  // Tap counts of the two averaging rings (1 to 16)
  localparam int VALVE_TAPS = 5;
  localparam int LEAK_TAPS  = 5;
  localparam int MAX_TAPS   = (VALVE_TAPS > LEAK_TAPS) ? VALVE_TAPS : LEAK_TAPS;
  localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);

  // Accumulator, magnitude and reciprocal sizing for the valve ring
  localparam int VALVE_ACC_W = SAMPLE_W + $clog2(VALVE_TAPS);
  localparam int VALVE_MAG_W = VALVE_ACC_W - 1;
  localparam int VALVE_SHIFT = VALVE_MAG_W + $clog2(VALVE_TAPS);
  localparam int VALVE_RECIP = ((1 << VALVE_SHIFT) + VALVE_TAPS - 1) / VALVE_TAPS;
  localparam int VALVE_PROD_W = 2 * VALVE_MAG_W + 1;

  // Accumulator, magnitude and reciprocal sizing for the leak ring
  localparam int LEAK_ACC_W  = SAMPLE_W + $clog2(LEAK_TAPS);
  localparam int LEAK_MAG_W  = LEAK_ACC_W - 1;
  localparam int LEAK_SHIFT  = LEAK_MAG_W + $clog2(LEAK_TAPS);
  localparam int LEAK_RECIP  = ((1 << LEAK_SHIFT) + LEAK_TAPS - 1) / LEAK_TAPS;
  localparam int LEAK_PROD_W = 2 * LEAK_MAG_W + 1;

  localparam logic [TIME_W-1:0] LEAK_LIMIT_RESET = 16'd2500;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] patient_pressure;
    logic signed [SAMPLE_W-1:0] valve_pressure;
    logic signed [SAMPLE_W-1:0] inspiratory_flow;
    logic [TIME_W-1:0]          exhale_time;
    logic                       disconnect_flag;
    logic                       disconnect_alarm;
    logic                       restart_sum;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0]       valve_pressure_mean;
    logic [MEAN_W-1:0]       leak_flow_mean;
    logic signed [SUM_W-1:0] pressure_sum;
    logic [COUNT_W-1:0]      pressure_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_MUL,
    S_OUT
  } state_t;

endpackage

/* sv/epa_in_if.sv */
// Sample request channel carrying one exhalation tick.
interface epa_in_if;
  import epa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/epa_out_if.sv */
// Result request channel carrying the averaged values.
interface epa_out_if;
  import epa_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/epa_cfg_if.sv */
// Configuration write channel for the leak time limit.
interface epa_cfg_if;
  import epa_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/exhale_plateau_averager.sv */
// Exhale plateau averager: tap rings, running sum and result register.
// Requests are taken only in the idle state, so a new request waits until the
// previous one has been rotated through the longer tap chain, multiplied and
// loaded into the result register.
// Reset (rst, synchronous): rings, sum, count and held leak mean clear to zero,
// the leak time limit returns to 2500, no result is pending.
module exhale_plateau_averager (
  input logic      clk,
  input logic      rst,
  epa_in_if.sink   samples,
  epa_out_if.source result,
  epa_cfg_if.sink  cfg
);
  import epa_pkg::*;

  state_t state, state_next;
  logic [TAP_CNT_W-1:0] cnt;
  logic in_ready, acc_en, mul_en, out_load;
  logic accept;

  logic [TIME_W-1:0] leak_limit;
  logic signed [SUM_W-1:0] sum_reg;
  logic [COUNT_W-1:0] count_reg;
  logic [MEAN_W-1:0] leak_held;
  logic leak_upd, leak_zero;
  logic leak_upd_in, disc_in;

  sample_t valve_q [VALVE_TAPS];
  sample_t valve_d [VALVE_TAPS];
  sample_t leak_q [LEAK_TAPS];
  sample_t leak_d [LEAK_TAPS];
  logic valve_shift, leak_shift, valve_rot, leak_rot;

  logic signed [VALVE_ACC_W-1:0] valve_acc;
  logic signed [LEAK_ACC_W-1:0]  leak_acc;
  logic [VALVE_MAG_W-1:0] valve_mag;
  logic [LEAK_MAG_W-1:0]  leak_mag;
  logic [VALVE_PROD_W-1:0] valve_prod;
  logic [LEAK_PROD_W-1:0]  leak_prod;
  logic [MEAN_W-1:0] valve_mean, leak_mean, leak_held_next;

  logic res_valid;
  out_item_t res_data;

  assign accept = samples.valid && in_ready;
  assign samples.ready = in_ready;
  assign cfg.ready = 1'b1;

  // Decode the leak decision of the incoming request
  assign disc_in = samples.data.disconnect_flag || samples.data.disconnect_alarm;
  assign leak_upd_in = !disc_in && (samples.data.exhale_time < leak_limit);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (samples.valid) state_next = S_ACC;
      S_ACC:  if (cnt == TAP_CNT_W'(MAX_TAPS - 1)) state_next = S_MUL;
      S_MUL:  state_next = S_OUT;
      S_OUT:  if (!res_valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    in_ready = 1'b0;
    acc_en   = 1'b0;
    mul_en   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_ACC:  acc_en = 1'b1;
      S_MUL:  mul_en = 1'b1;
      S_OUT:  out_load = !res_valid || result.ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step the rotation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (acc_en) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Hold the leak time limit
  always_ff @(posedge clk) begin
    if (rst) begin
      leak_limit <= LEAK_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      leak_limit <= cfg.data;
    end
  end

  // Update running sum and count, latch the leak decision
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_reg   <= '0;
      count_reg <= '0;
      leak_upd  <= 1'b0;
      leak_zero <= 1'b0;
    end else if (accept) begin
      sum_reg <= (samples.data.restart_sum ? '0 : sum_reg)
                 + SUM_W'(samples.data.patient_pressure);
      count_reg <= (samples.data.restart_sum ? '0 : count_reg) + 1'b1;
      leak_upd  <= leak_upd_in;
      leak_zero <= disc_in;
    end
  end

  // Insert a new sample at the head, or rotate the tail back around
  assign valve_rot   = acc_en && (cnt < TAP_CNT_W'(VALVE_TAPS));
  assign leak_rot    = acc_en && (cnt < TAP_CNT_W'(LEAK_TAPS));
  assign valve_shift = accept || valve_rot;
  assign leak_shift  = (accept && leak_upd_in) || leak_rot;

  for (genvar i = 0; i < VALVE_TAPS; i++) begin : g_valve
    if (i == 0) begin : g_head
      assign valve_d[i] = accept ? samples.data.valve_pressure : valve_q[VALVE_TAPS-1];
    end else begin : g_body
      assign valve_d[i] = valve_q[i-1];
    end
    epa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (valve_shift),
      .d     (valve_d[i]),
      .q     (valve_q[i])
    );
  end

  for (genvar i = 0; i < LEAK_TAPS; i++) begin : g_leak
    if (i == 0) begin : g_head
      assign leak_d[i] = accept ? samples.data.inspiratory_flow : leak_q[LEAK_TAPS-1];
    end else begin : g_body
      assign leak_d[i] = leak_q[i-1];
    end
    epa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (leak_shift),
      .d     (leak_d[i]),
      .q     (leak_q[i])
    );
  end

  // Accumulate the tail cell while the ring rotates
  always_ff @(posedge clk) begin
    if (accept) begin
      valve_acc <= '0;
      leak_acc  <= '0;
    end else begin
      if (valve_rot) valve_acc <= valve_acc + VALVE_ACC_W'(valve_q[VALVE_TAPS-1]);
      if (leak_rot)  leak_acc  <= leak_acc + LEAK_ACC_W'(leak_q[LEAK_TAPS-1]);
    end
  end

  // Clamp negatives, then divide by the tap count through a reciprocal
  assign valve_mag = valve_acc[VALVE_ACC_W-1] ? '0 : valve_acc[VALVE_MAG_W-1:0];
  assign leak_mag  = leak_acc[LEAK_ACC_W-1] ? '0 : leak_acc[LEAK_MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (mul_en) begin
      valve_prod <= VALVE_PROD_W'(valve_mag) * VALVE_PROD_W'(VALVE_RECIP);
      leak_prod  <= LEAK_PROD_W'(leak_mag) * LEAK_PROD_W'(LEAK_RECIP);
    end
  end

  assign valve_mean = valve_prod[VALVE_SHIFT +: MEAN_W];
  assign leak_mean  = leak_prod[LEAK_SHIFT +: MEAN_W];

  // Zero on disconnection, refresh below the limit, otherwise hold
  always_comb begin
    if (leak_zero) begin
      leak_held_next = '0;
    end else if (leak_upd) begin
      leak_held_next = leak_mean;
    end else begin
      leak_held_next = leak_held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_held <= '0;
    end else if (out_load) begin
      leak_held <= leak_held_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_data.valve_pressure_mean <= valve_mean;
      res_data.leak_flow_mean      <= leak_held_next;
      res_data.pressure_sum        <= sum_reg;
      res_data.pressure_count      <= count_reg;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

`ifndef SYNTHESIS
  a_accept_clears: assert property (@(posedge clk) disable iff (rst)
    accept |=> (cnt == '0) && (valve_acc == '0) && (leak_acc == '0))
    else $error("accumulators not cleared after request");

  a_full_rotation: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ($past(state) == S_ACC)
                         && ($past(cnt) == TAP_CNT_W'(MAX_TAPS - 1)))
    else $error("multiply entered before full rotation");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result.valid && (state == S_IDLE))
    else $error("result not presented after load");
`endif

endmodule

/* sv/epa_cell.sv */
// One tap cell of an averaging ring: holds a sample and passes it on.
module epa_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  epa_pkg::sample_t d,
  output epa_pkg::sample_t q
);
  import epa_pkg::*;

  // Take the neighbor's sample on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the exhale plateau averager.
module testbench;
  import epa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = MAX_TAPS + 8;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int PHASE_TICKS   = 130;
  localparam int HOLDOFF_AT    = 60;
  localparam int HOLDOFF_LEN   = 300;
  localparam int REPORT_CAP    = 50;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } stall_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  epa_in_if  samples_if ();
  epa_out_if result_if ();
  epa_cfg_if cfg_if ();

  exhale_plateau_averager dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .result  (result_if),
    .cfg     (cfg_if)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state
  sample_t             valve_hist [VALVE_TAPS];
  sample_t             leak_hist [LEAK_TAPS];
  int                  valve_pos;
  int                  leak_pos;
  logic [MEAN_W-1:0]   leak_mean_kept;
  logic [SUM_W-1:0]    pressure_total;
  logic [COUNT_W-1:0]  sample_tally;
  logic [TIME_W-1:0]   leak_limit;

  in_item_t  tick_queue[$];
  out_item_t pending_means[$];

  int   mismatch_count = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  logic tick_taken = 1'b0;

  // Sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall state
  stall_e stall_mode = RX_OPEN;
  int     segment_left = 0;
  int     stall_phase = 0;
  int     holdoff_left = 0;
  logic   holdoff_done = 1'b0;

  // Truncate toward zero, clamp negatives to zero
  function automatic logic [MEAN_W-1:0] clamp_mean(input int total, input int taps);
    int q;
    q = total / taps;
    if (q < 0) q = 0;
    return q[MEAN_W-1:0];
  endfunction

  // Apply one tick to the predicted state and return the averaged values
  function automatic out_item_t advance_averager(input in_item_t s);
    out_item_t r;
    int        total;
    if (s.restart_sum) begin
      pressure_total = '0;
      sample_tally = '0;
    end
    pressure_total = pressure_total + {{(SUM_W-SAMPLE_W){s.patient_pressure[SAMPLE_W-1]}},
                                       s.patient_pressure};
    sample_tally = sample_tally + 1'b1;

    valve_hist[valve_pos] = s.valve_pressure;
    valve_pos = (valve_pos + 1) % VALVE_TAPS;
    total = 0;
    for (int k = 0; k < VALVE_TAPS; k++) total += int'(valve_hist[k]);
    r.valve_pressure_mean = clamp_mean(total, VALVE_TAPS);

    // Disconnection wins over the time limit
    if (s.disconnect_flag || s.disconnect_alarm) begin
      leak_mean_kept = '0;
    end else if (s.exhale_time < leak_limit) begin
      leak_hist[leak_pos] = s.inspiratory_flow;
      leak_pos = (leak_pos + 1) % LEAK_TAPS;
      total = 0;
      for (int k = 0; k < LEAK_TAPS; k++) total += int'(leak_hist[k]);
      leak_mean_kept = clamp_mean(total, LEAK_TAPS);
    end

    r.leak_flow_mean = leak_mean_kept;
    r.pressure_sum = pressure_total;
    r.pressure_count = sample_tally;
    return r;
  endfunction

  function automatic in_item_t tick(input int pp, input int vp, input int qi, input int te,
                                    input bit df, input bit da, input bit rs);
    in_item_t t;
    t.patient_pressure = sample_t'(pp);
    t.valve_pressure = sample_t'(vp);
    t.inspiratory_flow = sample_t'(qi);
    t.exhale_time = TIME_W'(te);
    t.disconnect_flag = df;
    t.disconnect_alarm = da;
    t.restart_sum = rs;
    return t;
  endfunction

  // Mix extremes, small values near zero and full-range values
  function automatic sample_t pick_sample(input int spread);
    case ($urandom_range(0, 7))
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2, 3: return sample_t'(int'($urandom_range(0, 2 * spread)) - spread);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_tick();
    in_item_t t;
    int       lim_lo;
    int       lim_hi;
    lim_lo = (int'(leak_limit) > 3) ? int'(leak_limit) - 3 : 0;
    lim_hi = (int'(leak_limit) < 65532) ? int'(leak_limit) + 3 : 65535;
    t.patient_pressure = pick_sample(200);
    t.valve_pressure = pick_sample(12);
    t.inspiratory_flow = pick_sample(12);
    case ($urandom_range(0, 3))
      0: t.exhale_time = TIME_W'($urandom);
      1: t.exhale_time = TIME_W'($urandom_range(0, 2));
      default: t.exhale_time = TIME_W'($urandom_range(lim_lo, lim_hi));
    endcase
    t.disconnect_flag = ($urandom_range(0, 7) == 0);
    t.disconnect_alarm = ($urandom_range(0, 7) == 0);
    t.restart_sum = ($urandom_range(0, 15) == 0);
    return t;
  endfunction

  // Sample driver: bursts of requests with random gaps, changes at falling edge
  always @(negedge clk) begin : sample_driver
    logic     next_valid;
    in_item_t next_data;
    next_valid = samples_if.valid;
    next_data = samples_if.data;
    if (!samples_if.valid || tick_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (tick_queue.size() > 0) begin
        next_data = tick_queue.pop_front();
        next_valid = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      end
    end
    samples_if.valid <= next_valid;
    samples_if.data <= next_data;
  end

  // Result receiver: stall pattern per segment, one long hold-off
  always @(negedge clk) begin : result_receiver
    logic ready_next;
    ready_next = 1'b1;
    stall_phase = (stall_phase + 1) % 3;
    if (holdoff_left > 0) begin
      holdoff_left--;
      ready_next = 1'b0;
    end else if (!holdoff_done && results_seen == HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      ready_next = 1'b0;
    end else begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(8, 64);
        stall_mode = stall_e'($urandom_range(0, 3));
      end
      segment_left--;
      case (stall_mode)
        RX_OPEN:     ready_next = 1'b1;
        RX_COIN:     ready_next = ($urandom_range(0, 1) == 1);
        RX_SPARSE:   ready_next = ($urandom_range(0, 3) == 0);
        RX_PERIODIC: ready_next = (stall_phase != 0);
      endcase
    end
    result_if.ready <= ready_next;
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) leak_limit = cfg_if.data;
      if (samples_if.valid && samples_if.ready)
        pending_means.push_back(advance_averager(samples_if.data));
      if (result_if.valid && result_if.ready) begin
        got = result_if.data;
        results_seen++;
        if (pending_means.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP) $error("result with no request pending");
        end else begin
          want = pending_means.pop_front();
          if (got.valve_pressure_mean !== want.valve_pressure_mean) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("valve_pressure_mean: expected %0d, got %0d",
                     want.valve_pressure_mean, got.valve_pressure_mean);
          end
          if (got.leak_flow_mean !== want.leak_flow_mean) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("leak_flow_mean: expected %0d, got %0d",
                     want.leak_flow_mean, got.leak_flow_mean);
          end
          if (got.pressure_sum !== want.pressure_sum) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("pressure_sum: expected %0d, got %0d",
                     want.pressure_sum, got.pressure_sum);
          end
          if (got.pressure_count !== want.pressure_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("pressure_count: expected %0d, got %0d",
                     want.pressure_count, got.pressure_count);
          end
        end
      end
    end
    tick_taken <= !rst && samples_if.valid && samples_if.ready;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Wait until every request has been answered, then let the pipeline settle
  task automatic drain();
    while (tick_queue.size() != 0 || samples_if.valid || pending_means.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_if.data <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [TIME_W-1:0] limit);
    write_limit(limit);
    repeat (PHASE_TICKS) tick_queue.push_back(random_tick());
    drain();
  endtask

  initial begin
    // Known values on every input from time zero
    samples_if.valid = 1'b0;
    samples_if.data = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int k = 0; k < VALVE_TAPS; k++) valve_hist[k] = '0;
    for (int k = 0; k < LEAK_TAPS; k++) leak_hist[k] = '0;
    valve_pos = 0;
    leak_pos = 0;
    leak_mean_kept = '0;
    pressure_total = '0;
    sample_tally = '0;
    leak_limit = LEAK_LIMIT_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, clamping, truncation, limit edges, disconnection
    tick_queue.push_back(tick(0, 0, 0, 0, 0, 0, 1));
    repeat (5) tick_queue.push_back(tick(32767, 32767, 32767, 0, 0, 0, 0));
    repeat (5) tick_queue.push_back(tick(-32768, -32768, -32768, 2499, 0, 0, 0));
    tick_queue.push_back(tick(1, 1000, 1000, 2500, 0, 0, 0));
    tick_queue.push_back(tick(-1, 1000, 1000, 65535, 0, 0, 0));
    tick_queue.push_back(tick(5, -1, -1, 0, 0, 0, 0));
    tick_queue.push_back(tick(5, -1, -1, 1, 0, 0, 0));
    tick_queue.push_back(tick(5, -1, 9, 2, 0, 0, 0));
    tick_queue.push_back(tick(-32768, 1, 9, 3, 0, 0, 1));
    tick_queue.push_back(tick(7, 1, 9, 4, 0, 0, 0));
    tick_queue.push_back(tick(7, 9, 700, 10, 1, 0, 0));
    tick_queue.push_back(tick(7, 9, 700, 11, 0, 0, 0));
    tick_queue.push_back(tick(7, 9, 700, 65535, 0, 1, 0));
    tick_queue.push_back(tick(7, 9, 700, 12, 1, 1, 0));
    tick_queue.push_back(tick(32767, -32768, 32767, 2499, 0, 0, 1));
    tick_queue.push_back(tick(-32768, 32767, -32768, 2498, 0, 0, 0));
    drain();

    // Random phases over several limit settings, extremes included
    random_phase(TIME_W'(0));
    random_phase(TIME_W'(65535));
    random_phase(TIME_W'($urandom_range(2, 65533)));
    random_phase(TIME_W'(1));
    random_phase(TIME_W'($urandom_range(2000, 3000)));

    if (mismatch_count == 0 && pending_means.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
